// ----- hdl/xtea_pkg.sv -----
// Shared types, constants and constant functions for the XTEA cipher pipeline.
// No dependencies; compiled first.
package xtea_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned KEY_WORDS = 4;
    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_KEY_0 = 2'd0,
        REG_KEY_1 = 2'd1,
        REG_KEY_2 = 2'd2,
        REG_KEY_3 = 2'd3
    } t_cfg_reg;

    // Direction codes
    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    // Block in flight between cells
    typedef struct packed {
        logic  kind;
        t_word v0;
        t_word v1;
    } t_lane;

    // Running sum used by encryption half-round e (counted from zero).
    // Even half-rounds see (e/2)*delta, odd ones see the sum after the add.
    function automatic t_word half_sum(input int unsigned e);
        logic [63:0] prod;
        prod = 64'((e + 1) >> 1) * 64'(DELTA);
        return prod[WORD_W-1:0];
    endfunction

    // Key word index used by encryption half-round e
    function automatic logic [1:0] half_key_sel(input int unsigned e);
        t_word s;
        s = half_sum(e);
        return ((e % 2) == 1) ? s[12:11] : s[1:0];
    endfunction

endpackage

// ----- hdl/xtea_in_if.sv -----
// Input channel of the XTEA cipher: direction flag and the two block halves.
// Stand-alone interface, no dependencies.
interface xtea_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] block_low;
    logic [31:0] block_high;

    modport source (output valid, output kind, output block_low, output block_high,
                    input ready);
    modport sink   (input valid, input kind, input block_low, input block_high,
                    output ready);
endinterface

// ----- hdl/xtea_out_if.sv -----
// Output channel of the XTEA cipher: the two halves of the transformed block.
// Stand-alone interface, no dependencies.
interface xtea_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_low;
    logic [31:0] result_high;

    modport source (output valid, output result_low, output result_high, input ready);
    modport sink   (input valid, input result_low, input result_high, output ready);
endinterface

// ----- hdl/xtea_block_cipher.sv -----
// Top level of the XTEA block cipher: key registers and a row of half-round cells.
// Depends on xtea_pkg, xtea_in_if, xtea_out_if and xtea_cell.
//
//  Channel   Direction  Payload                       Handshake
//  i_blk     in         kind, block_low, block_high   valid/ready
//  o_res     out        result_low, result_high       valid/ready
//  i_cfg_*   in         index 0..3 key words          write enable, no wait
//
// One block enters per cycle while no stall fills the row; each result is registered
// once in every cell, one half-round per cell, and held in the last cell until taken.
// Reset clears the key words to zero and empties every cell.
// A stalled output holds the last cell; earlier cells keep filling bubbles, so
// input is taken while any cell is empty.
module xtea_block_cipher #(
    parameter int unsigned ROUNDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xtea_in_if.sink     i_blk,
    xtea_out_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import xtea_pkg::*;

    localparam int unsigned STAGES = 2 * ROUNDS;

    t_key  r_key;
    logic  w_valid [0:STAGES];
    logic  w_ready [0:STAGES];
    t_lane w_lane  [0:STAGES];
    logic  [STAGES-1:0] w_vbits;
    logic  w_in_acc;
    logic  w_out_acc;

    // Key register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_KEY_0: r_key[0] <= i_cfg_data;
                REG_KEY_1: r_key[1] <= i_cfg_data;
                REG_KEY_2: r_key[2] <= i_cfg_data;
                REG_KEY_3: r_key[3] <= i_cfg_data;
                default:   r_key    <= r_key;
            endcase
        end
    end

    // Input side of the row
    assign w_valid[0]     = i_blk.valid;
    assign w_lane[0].kind = i_blk.kind;
    assign w_lane[0].v0   = i_blk.block_low;
    assign w_lane[0].v1   = i_blk.block_high;
    assign i_blk.ready    = w_ready[0];

    // Row of half-round cells
    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        xtea_cell #(
            .P_INDEX  (g),
            .P_STAGES (STAGES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .o_ready (w_ready[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1]),
            .i_ready (w_ready[g+1])
        );
        assign w_vbits[g] = w_valid[g+1];
    end

    // Output side: the last cell register drives the channel
    assign o_res.valid       = w_valid[STAGES];
    assign o_res.result_low  = w_lane[STAGES].v0;
    assign o_res.result_high = w_lane[STAGES].v1;
    assign w_ready[STAGES]   = o_res.ready;

    assign w_in_acc  = i_blk.valid && i_blk.ready;
    assign w_out_acc = o_res.valid && o_res.ready;

    // A taken block lands in the first cell
    a_first_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> w_vbits[0])
        else $error("accepted block missing from first cell");

    // Occupancy changes only by input and output transactions
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(w_vbits) ==
            $countones($past(w_vbits)) + int'($past(w_in_acc)) - int'($past(w_out_acc))))
        else $error("block lost or duplicated in the cell row");

    // With the output stalled, input is taken exactly while a bubble remains
    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> (i_blk.ready == (w_vbits != '1)))
        else $error("input ready does not match free cells");

    // A key write to word 0 lands in that word
    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == REG_KEY_0)) |=> (r_key[0] == $past(i_cfg_data)))
        else $error("key word 0 write lost");

endmodule

// ----- hdl/xtea_cell.sv -----
// One pipeline cell of the XTEA cipher: a single Feistel half-round and its register.
// Depends on xtea_pkg.
module xtea_cell #(
    parameter int unsigned P_INDEX  = 0,
    parameter int unsigned P_STAGES = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xtea_pkg::t_key   i_key,
    input  logic             i_valid,
    input  xtea_pkg::t_lane  i_lane,
    output logic             o_ready,
    output logic             o_valid,
    output xtea_pkg::t_lane  o_lane,
    input  logic             i_ready
);
    import xtea_pkg::*;

    // Decryption runs the encryption half-rounds back to front
    localparam int unsigned E_ENC = P_INDEX;
    localparam int unsigned E_DEC = P_STAGES - 1 - P_INDEX;
    localparam t_word       SUM_ENC = half_sum(E_ENC);
    localparam t_word       SUM_DEC = half_sum(E_DEC);
    localparam logic [1:0]  SEL_ENC = half_key_sel(E_ENC);
    localparam logic [1:0]  SEL_DEC = half_key_sel(E_DEC);
    localparam bit          EVEN    = ((P_INDEX % 2) == 0);

    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;
    logic  w_dec;
    logic  w_src_is_v0;
    t_word w_src;
    t_word w_dst;
    t_word w_mix;
    t_word w_sum;
    t_word w_ks;
    t_word w_mixed;
    t_word w_new;

    // Even cells: encrypt updates v0 from v1, decrypt updates v1 from v0; odd cells swap
    always_comb begin
        w_dec       = (i_lane.kind == KIND_DEC);
        w_src_is_v0 = EVEN ? w_dec : !w_dec;
        w_src       = w_src_is_v0 ? i_lane.v0 : i_lane.v1;
        w_dst       = w_src_is_v0 ? i_lane.v1 : i_lane.v0;
        w_mix       = ((w_src << 4) ^ (w_src >> 5)) + w_src;
        w_sum       = w_dec ? SUM_DEC : SUM_ENC;
        w_ks        = w_sum + i_key[w_dec ? SEL_DEC : SEL_ENC];
        w_mixed     = w_mix ^ w_ks;
        w_new       = w_dec ? (w_dst - w_mixed) : (w_dst + w_mixed);
        n_lane      = i_lane;
        if (w_src_is_v0) begin
            n_lane.v1 = w_new;
        end else begin
            n_lane.v0 = w_new;
        end
    end

    // Cell takes a new block when empty or when its content moves on
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ----- test/xtea_block_cipher_tb.sv -----
// Testbench for the XTEA block cipher: directed and random blocks in both
// directions, checked against a behavioural cipher model kept in the bench.
// Depends on xtea_pkg, xtea_in_if, xtea_out_if and the xtea_block_cipher RTL.
module xtea_block_cipher_tb;
    import xtea_pkg::*;

    localparam int unsigned ROUNDS        = 16;
    localparam int unsigned LATENCY       = 2 * ROUNDS;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 110;
    localparam t_word       ALL_ONES      = 32'hFFFF_FFFF;

    typedef struct packed {
        t_word lo;
        t_word hi;
    } t_block;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    xtea_in_if  blk_if ();
    xtea_out_if res_if ();

    xtea_block_cipher #(
        .ROUNDS(ROUNDS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_blk      (blk_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Bench copy of the key and the blocks still owed by the pipeline
    t_word       key_shadow [KEY_WORDS];
    t_block      expected_blocks [$];
    bit          source_gaps;
    bit          sink_stalls;
    int unsigned error_count;
    int unsigned enc_sent;
    int unsigned dec_sent;
    int unsigned blocks_checked;
    int unsigned key_loads;
    int unsigned cycle_count;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run-away guard
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d blocks still pending", expected_blocks.size());
            $display("xtea_block_cipher test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Cipher model
    // ---------------------------------------------------------------------

    function automatic t_word feistel_mix(input t_word v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function automatic t_block xtea_transform(input logic kind, input t_block blk);
        t_word       v0;
        t_word       v1;
        t_word       s;
        int unsigned n;
        v0 = blk.lo;
        v1 = blk.hi;
        if (kind == KIND_ENC) begin
            s = '0;
            for (n = 0; n < ROUNDS; n++) begin
                v0 = v0 + (feistel_mix(v1) ^ (s + key_shadow[s[1:0]]));
                s  = s + DELTA;
                v1 = v1 + (feistel_mix(v0) ^ (s + key_shadow[s[12:11]]));
            end
        end else begin
            // sum wraps to 32 bits
            s = DELTA * t_word'(ROUNDS);
            for (n = 0; n < ROUNDS; n++) begin
                v1 = v1 - (feistel_mix(v0) ^ (s + key_shadow[s[12:11]]));
                s  = s - DELTA;
                v0 = v0 - (feistel_mix(v1) ^ (s + key_shadow[s[1:0]]));
            end
        end
        return '{lo: v0, hi: v1};
    endfunction

    // ---------------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0d] MISMATCH: %s", cycle_count, what);
        error_count++;
    endtask

    // Mostly random words, with extremes and single-bit patterns mixed in
    function automatic t_word pattern_word();
        t_word one_hot;
        one_hot = t_word'(1) << $urandom_range(0, 31);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            2: return one_hot;
            3: return ~one_hot;
            default: return t_word'($urandom());
        endcase
    endfunction

    function automatic t_block pattern_block();
        return '{lo: pattern_word(), hi: pattern_word()};
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input t_word data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Only called with the pipeline empty
    task automatic load_key(input t_word k0, input t_word k1, input t_word k2, input t_word k3);
        write_reg(REG_KEY_0, k0);
        write_reg(REG_KEY_1, k1);
        write_reg(REG_KEY_2, k2);
        write_reg(REG_KEY_3, k3);
        i_cfg_we <= 1'b0;
        key_shadow[REG_KEY_0] = k0;
        key_shadow[REG_KEY_1] = k1;
        key_shadow[REG_KEY_2] = k2;
        key_shadow[REG_KEY_3] = k3;
        key_loads++;
    endtask

    // Drive one block and hold it until the transaction completes
    task automatic send_block(input logic kind, input t_block blk);
        int unsigned gap;
        gap = source_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            blk_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        blk_if.valid      <= 1'b1;
        blk_if.kind       <= kind;
        blk_if.block_low  <= blk.lo;
        blk_if.block_high <= blk.hi;
        do @(posedge i_clk); while (blk_if.ready !== 1'b1);
        expected_blocks.push_back(xtea_transform(kind, blk));
        if (kind == KIND_ENC) enc_sent++;
        else dec_sent++;
    endtask

    // Encrypt a block, then decrypt its ciphertext straight back
    task automatic send_round_trip(input t_block blk);
        send_block(KIND_ENC, blk);
        send_block(KIND_DEC, xtea_transform(KIND_ENC, blk));
    endtask

    // Stop sending and wait for the pipeline to empty
    task automatic wait_for_results();
        blk_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_blocks.size() != 0);
    endtask

    // ---------------------------------------------------------------------
    // Result side: random stalls, compare each transaction in order
    // ---------------------------------------------------------------------

    initial begin : result_sink
        int unsigned stall;
        t_block      want;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = sink_stalls ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            if (expected_blocks.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h_%h",
                                          res_if.result_high, res_if.result_low));
            end else begin
                want = expected_blocks.pop_front();
                if (res_if.result_low !== want.lo)
                    report_mismatch($sformatf("result_low %h, want %h",
                                              res_if.result_low, want.lo));
                if (res_if.result_high !== want.hi)
                    report_mismatch($sformatf("result_high %h, want %h",
                                              res_if.result_high, want.hi));
                blocks_checked++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Key registers read as zero before any write
    task automatic test_reset_key();
        send_block(KIND_ENC, '{lo: '0, hi: '0});
        send_block(KIND_DEC, '{lo: '0, hi: '0});
        send_block(KIND_ENC, '{lo: ALL_ONES, hi: ALL_ONES});
        send_block(KIND_DEC, '{lo: ALL_ONES, hi: ALL_ONES});
        wait_for_results();
    endtask

    // Extreme blocks under an all-ones key, then a key with distinct words
    task automatic test_directed_extremes();
        load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_block(KIND_ENC, '{lo: '0, hi: ALL_ONES});
        send_block(KIND_DEC, '{lo: '0, hi: ALL_ONES});
        send_block(KIND_ENC, '{lo: ALL_ONES, hi: '0});
        send_block(KIND_DEC, '{lo: ALL_ONES, hi: '0});
        send_block(KIND_ENC, '{lo: 32'hAAAA_AAAA, hi: 32'h5555_5555});
        send_block(KIND_DEC, '{lo: 32'h5555_5555, hi: 32'hAAAA_AAAA});
        send_round_trip('{lo: 32'h0123_4567, hi: 32'h89AB_CDEF});
        wait_for_results();
        // every key word different, so a wrong word select shows up
        load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
        send_block(KIND_ENC, '{lo: '0, hi: '0});
        send_block(KIND_DEC, '{lo: '0, hi: '0});
        send_round_trip('{lo: 32'hDEAD_BEEF, hi: 32'hCAFE_F00D});
        wait_for_results();
    endtask

    // Sender holds off mid-stream until everything outstanding has come back
    task automatic test_pause_drain();
        int unsigned i;
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        load_key(pattern_word(), pattern_word(), pattern_word(), pattern_word());
        for (i = 0; i < 30; i++) begin
            send_block(logic'($urandom_range(0, 1)), pattern_block());
            if (i == 14) wait_for_results();
        end
        wait_for_results();
    endtask

    // Phases of random traffic, each under its own key and idling mix
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned sent;
        t_block      blk;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
                1: load_key('0, '0, '0, ALL_ONES);
                2: load_key(ALL_ONES, '0, '0, '0);
                3: load_key('0, '0, '0, '0);
                default: load_key(pattern_word(), pattern_word(),
                                  pattern_word(), pattern_word());
            endcase
            source_gaps = phase[0];
            sink_stalls = phase[1];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                blk = pattern_block();
                if ($urandom_range(0, 3) == 0) begin
                    send_round_trip(blk);
                    sent += 2;
                end else begin
                    send_block(logic'($urandom_range(0, 1)), blk);
                    sent++;
                end
            end
            wait_for_results();
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial begin
        int unsigned i;
        error_count    = 0;
        enc_sent       = 0;
        dec_sent       = 0;
        blocks_checked = 0;
        key_loads      = 0;
        source_gaps    = 1'b0;
        sink_stalls    = 1'b0;
        for (i = 0; i < KEY_WORDS; i++) key_shadow[i] = '0;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= REG_KEY_0;
        i_cfg_data        <= '0;
        blk_if.valid      <= 1'b0;
        blk_if.kind       <= KIND_ENC;
        blk_if.block_low  <= '0;
        blk_if.block_high <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_key();
        test_directed_extremes();
        test_pause_drain();
        test_random_traffic();

        // let any stray result surface
        wait_for_results();
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("checked %0d blocks (%0d encrypt, %0d decrypt) under %0d key loads",
                 blocks_checked, enc_sent, dec_sent, key_loads);
        $display("random gaps and stalls on both channels, %0d mismatches", error_count);
        if (error_count == 0) begin
            $display("xtea_block_cipher test passed");
        end else begin
            $display("xtea_block_cipher test failed");
        end
        $finish;
    end

endmodule
